// File: sv/mmcn_pkg.sv
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared types and constants for the masked midrange center/normalize block.
// ----------------------------------------------------------------------------
package mmcn_pkg;

    localparam int MMCN_MAX_ELEMENTS = 64;

    localparam int SAMPLE_W  = 32;
    localparam int DIVISOR_W = 31;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 31'd65536;
    localparam logic [SAMPLE_W-1:0]  Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0]  Q_MIN         = 32'h8000_0000;

    // Register index codes, taken from paddr[2].
    localparam logic REG_SCALE_DIVISOR = 1'b0;
    localparam logic REG_UNMAPPED      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_FETCH,
        S_DIFF,
        S_WAIT
    } t_seq_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_SETUP,
        D_RUN,
        D_FIN
    } t_div_state;

    typedef struct packed {
        logic                 start;
        logic [DIFF_W-1:0]    diff;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] value;
    } t_div_rsp;

endpackage

// File: sv/masked_midrange_center_normalize.sv
// ----------------------------------------------------------------------------
// masked_midrange_center_normalize
// Buffers a sequence of Q16.16 samples, tracks min/max over the valid ones,
// and on the last request emits every stored sample centered on the midrange
// and divided by the configured divisor.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake                    | Payload
//  ----------+------------------------------+-----------------------------------
//  request   | start, busy (taken: start&!busy) | sample_value, sample_valid, last
//  result    | o_strobe, one cycle, no stall | normalized, center, last, flags
//  config    | APB psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  A request that is not marked last is taken and busy stays low.
//  A last request raises busy: the center is formed, then each stored
//  sample passes through memory read, subtract, setup, 32 steps of the
//  one-bit-per-cycle serial divider, finish and response.
//  Busy drops in the cycle that shows the final result.
//  Reset is synchronous and active low; the sample buffer is not cleared.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module masked_midrange_center_normalize #(
    parameter int MAX_ELEMENTS = mmcn_pkg::MMCN_MAX_ELEMENTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic [mmcn_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                          i_sample_valid,
    input  logic                          i_sequence_last,

    output logic                          o_strobe,
    output logic [mmcn_pkg::SAMPLE_W-1:0] o_normalized_value,
    output logic [mmcn_pkg::SAMPLE_W-1:0] o_center_value,
    output logic                          o_result_last,
    output logic                          o_no_valid_samples,
    output logic                          o_overflow_dropped,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmcn_pkg::PADDR_W-1:0]  paddr,
    input  logic [mmcn_pkg::PDATA_W-1:0]  pwdata,
    output logic [mmcn_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mmcn_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(MAX_ELEMENTS);

    t_seq_state r_state, n_state;

    // Configuration.
    logic [DIVISOR_W-1:0] r_divisor;

    // Per-sequence state.
    logic [CW-1:0]        r_count;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic                 r_any;
    logic                 r_ovf;
    logic [SAMPLE_W-1:0]  r_center;
    logic [CW-1:0]        r_idx;

    logic                 w_accept;
    logic                 w_room;
    logic                 w_store;
    logic                 w_cfg_wr;
    logic                 w_div_start;
    logic                 w_emit;
    logic                 w_final;
    logic [DIFF_W-1:0]    w_sum;
    logic [SAMPLE_W-1:0]  w_rdata;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    logic signed [SAMPLE_W-1:0] w_sample;

    assign w_sample = i_sample_value;
    assign w_accept = start && !busy;
    assign w_room   = (r_count < DEPTH_C);
    assign w_store  = w_accept && w_room;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // The divider's response marks the point where one result is ready.
    assign w_emit  = (r_state == S_WAIT) && w_div_rsp.done;
    assign w_final = w_emit && (r_idx == r_count - CW'(1));

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept && i_sequence_last) n_state = S_CENTER;
            S_CENTER: n_state = S_FETCH;
            S_FETCH:  n_state = S_DIFF;
            S_DIFF:   n_state = S_WAIT;
            S_WAIT: begin
                if (w_emit) begin
                    n_state = w_final ? S_IDLE : S_FETCH;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE:  busy        = 1'b0;
            S_DIFF:  w_div_start = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sample buffer and shared divider.
    // ------------------------------------------------------------------------
    mmcn_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_sample_value),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Both operands are 32-bit signed values, so the difference fits in 33 bits.
    assign w_div_req.start   = w_div_start;
    assign w_div_req.diff    = {w_rdata[SAMPLE_W-1], w_rdata}
                             - {r_center[SAMPLE_W-1], r_center};
    assign w_div_req.divisor = r_divisor;

    mmcn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Midrange with rounding toward minus infinity: the exact 33-bit sum,
    // arithmetically shifted right by one.
    assign w_sum = {r_min[SAMPLE_W-1], r_min} + {r_max[SAMPLE_W-1], r_max};

    // ------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_divisor <= DIVISOR_RESET;
            r_count   <= '0;
            r_min     <= Q_MAX;
            r_max     <= Q_MIN;
            r_any     <= 1'b0;
            r_ovf     <= 1'b0;
            r_idx     <= '0;
            o_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= w_emit;

            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_SCALE_DIVISOR: r_divisor <= pwdata[DIVISOR_W-1:0];
                    REG_UNMAPPED:      ;
                    default:           ;
                endcase
            end

            if (w_accept) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                    if (i_sample_valid) begin
                        if (w_sample < r_min) r_min <= w_sample;
                        if (w_sample > r_max) r_max <= w_sample;
                        r_any <= 1'b1;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (r_state == S_CENTER) begin
                r_idx <= '0;
            end else if (w_emit && !w_final) begin
                r_idx <= r_idx + CW'(1);
            end

            // The sequence state returns to its reset values once the final
            // result has been captured into the output registers.
            if (w_final) begin
                r_count <= '0;
                r_min   <= Q_MAX;
                r_max   <= Q_MIN;
                r_any   <= 1'b0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_CENTER) begin
            r_center <= r_any ? w_sum[DIFF_W-1:1] : '0;
        end
        if (w_emit) begin
            o_normalized_value <= w_div_rsp.value;
            o_center_value     <= r_center;
            o_result_last      <= w_final;
            o_no_valid_samples <= !r_any;
            o_overflow_dropped <= r_ovf;
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[2])
            REG_SCALE_DIVISOR: prdata = {1'b0, r_divisor};
            REG_UNMAPPED:      prdata = '0;
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_sequence_last) |=> busy)
        else $error("last request did not start the emission pass");

    a_final_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_last) |-> !busy)
        else $error("still busy after the final result");

    a_mid_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result_last) |-> busy)
        else $error("left the emission pass before the final result");

    // The read index is cleared while the center is formed, so it is only
    // meaningful from the first fetch on.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_CENTER) |-> (r_idx < r_count))
        else $error("read index beyond the stored samples");

endmodule

// File: sv/mmcn_store.sv
// ----------------------------------------------------------------------------
// mmcn_store
// Sample buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmcn_store #(
    parameter int DEPTH = mmcn_pkg::MMCN_MAX_ELEMENTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [mmcn_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [mmcn_pkg::SAMPLE_W-1:0] o_rdata
);
    import mmcn_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mmcn_div.sv
// ----------------------------------------------------------------------------
// mmcn_div
// Serial restoring divider: (diff * 65536) / divisor, truncated toward zero
// and saturated to Q16.16. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmcn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmcn_pkg::t_div_req i_req,
    output mmcn_pkg::t_div_rsp o_rsp
);
    import mmcn_pkg::*;

    t_div_state r_state, n_state;

    logic [DIFF_W-1:0]    r_diff;
    logic [DIVISOR_W-1:0] r_div;
    logic                 r_neg;
    logic                 r_over;
    logic [DIVISOR_W-1:0] r_rem;
    logic [SAMPLE_W-1:0]  r_shift;
    logic [SAMPLE_W-1:0]  r_q;
    logic [4:0]           r_cnt;
    logic [SAMPLE_W-1:0]  r_result;
    logic                 r_done;

    logic                 w_load;
    logic                 w_setup;
    logic                 w_step;
    logic                 w_fin;
    logic [DIFF_W-1:0]    w_mag;
    logic [SAMPLE_W-1:0]  w_trial;
    logic                 w_ge;
    logic [SAMPLE_W-1:0]  w_sat;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_req.start) n_state = D_SETUP;
            D_SETUP: n_state = D_RUN;
            D_RUN:   if (r_cnt == 5'd31) n_state = D_FIN;
            D_FIN:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_comb begin
        w_load  = 1'b0;
        w_setup = 1'b0;
        w_step  = 1'b0;
        w_fin   = 1'b0;
        unique case (r_state)
            D_IDLE:  w_load  = i_req.start;
            D_SETUP: w_setup = 1'b1;
            D_RUN:   w_step  = 1'b1;
            D_FIN:   w_fin   = 1'b1;
            default: ;
        endcase
    end

    // Magnitude of the difference; -2^32 still fits as an unsigned 33-bit value.
    assign w_mag   = r_diff[DIFF_W-1] ? (~r_diff + 33'd1) : r_diff;
    assign w_trial = {r_rem, r_shift[SAMPLE_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // A quotient at or above 2^31 clips; for a negative result exactly 2^31
    // lands on the most negative code anyway.
    always_comb begin
        if (r_over || r_q[SAMPLE_W-1]) begin
            w_sat = r_neg ? Q_MIN : Q_MAX;
        end else begin
            w_sat = r_neg ? (~r_q + 32'd1) : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_diff <= i_req.diff;
            r_div  <= (i_req.divisor == '0) ? 31'd1 : i_req.divisor;
        end
        if (w_setup) begin
            r_neg   <= r_diff[DIFF_W-1];
            // The quotient reaches 2^32 exactly when the upper part alone
            // is no smaller than the divisor.
            r_over  <= ({14'd0, w_mag[32:16]} >= r_div);
            r_rem   <= {14'd0, w_mag[32:16]};
            r_shift <= {w_mag[15:0], 16'd0};
            r_q     <= '0;
            r_cnt   <= '0;
        end
        if (w_step) begin
            r_rem   <= w_ge ? w_trial[DIVISOR_W-1:0] - r_div : w_trial[DIVISOR_W-1:0];
            r_q     <= {r_q[SAMPLE_W-2:0], w_ge};
            r_shift <= {r_shift[SAMPLE_W-2:0], 1'b0};
            r_cnt   <= r_cnt + 5'd1;
        end
        if (w_fin) begin
            r_result <= w_sat;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_result;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for masked_midrange_center_normalize. Sequences of
// Q16.16 sample requests are driven through the start/busy handshake, a
// scoreboard predicts the midrange-centered and scaled results of every
// sequence, and each strobed result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmcn_pkg::*;

    localparam int DEPTH        = MMCN_MAX_ELEMENTS;
    localparam int RANDOM_ITEMS = 410;
    localparam int SETTLE       = 100;      // longer than a per-sample divide
    localparam int CYCLE_LIMIT  = 4000000;

    // One expected or observed result.
    typedef struct packed {
        logic [SAMPLE_W-1:0] norm;
        logic [SAMPLE_W-1:0] center;
        logic                last;
        logic                none_valid;
        logic                dropped;
    } t_norm_result;

    // The scoreboard holds its own copy of the sequence state and the divisor.
    // A last request turns the buffered samples into a list of expected results.
    class norm_scoreboard;
        logic signed [SAMPLE_W-1:0] samples[$];
        longint                     lo_val;
        longint                     hi_val;
        bit                         seen_valid;
        bit                         saw_drop;
        logic [DIVISOR_W-1:0]       divisor;
        t_norm_result               pending_results[$];
        int                         errors;

        function new();
            divisor = DIVISOR_RESET;
            errors  = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            samples.delete();
            lo_val     = 64'sd2147483647;
            hi_val     = -64'sd2147483648;
            seen_valid = 1'b0;
            saw_drop   = 1'b0;
        endfunction

        function void set_divisor(logic [DIVISOR_W-1:0] value);
            divisor = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int failures();
            return errors + pending_results.size();
        endfunction

        function void note_request(logic [SAMPLE_W-1:0] value, logic valid, logic last);
            longint       s;
            longint       mid;
            longint       d;
            longint       q;
            t_norm_result r;
            s = longint'($signed(value));
            if (samples.size() < DEPTH) begin
                samples.push_back(value);
                if (valid) begin
                    if (s < lo_val) lo_val = s;
                    if (s > hi_val) hi_val = s;
                    seen_valid = 1'b1;
                end
            end else begin
                saw_drop = 1'b1;
            end
            if (!last) return;
            // Midrange is halved with rounding toward minus infinity.
            mid = seen_valid ? ((lo_val + hi_val) >>> 1) : 64'sd0;
            d   = (divisor == '0) ? 64'sd1 : longint'(divisor);
            foreach (samples[k]) begin
                q = ((longint'(samples[k]) - mid) * 64'sd65536) / d;
                if (q > 64'sd2147483647)  q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                r.norm       = q[SAMPLE_W-1:0];
                r.center     = mid[SAMPLE_W-1:0];
                r.last       = (k == samples.size() - 1);
                r.none_valid = !seen_valid;
                r.dropped    = saw_drop;
                pending_results.push_back(r);
            end
            clear_sequence();
        endfunction

        function void check_result(t_norm_result got);
            t_norm_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: unexpected result norm=%h center=%h last=%b",
                              " none=%b drop=%b"},
                             got.norm, got.center, got.last, got.none_valid, got.dropped);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result differs  exp norm=%h center=%h last=%b",
                              " none=%b drop=%b  got norm=%h center=%h last=%b",
                              " none=%b drop=%b"},
                             want.norm, want.center, want.last, want.none_valid,
                             want.dropped,
                             got.norm, got.center, got.last, got.none_valid, got.dropped);
            end
        endfunction
    endclass

    // Clock, reset and every input of the block start at known values.
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic [SAMPLE_W-1:0] i_sample_value  = '0;
    logic                i_sample_valid  = 1'b0;
    logic                i_sequence_last = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [PADDR_W-1:0]  paddr           = '0;
    logic [PDATA_W-1:0]  pwdata          = '0;

    logic                busy;
    logic                o_strobe;
    logic [SAMPLE_W-1:0] o_normalized_value;
    logic [SAMPLE_W-1:0] o_center_value;
    logic                o_result_last;
    logic                o_no_valid_samples;
    logic                o_overflow_dropped;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    norm_scoreboard sb = new();
    bit             gaps_on = 1'b1;     // random idle cycles on the request side
    int             cycles  = 0;

    masked_midrange_center_normalize uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_sample_value     (i_sample_value),
        .i_sample_valid     (i_sample_valid),
        .i_sequence_last    (i_sequence_last),
        .o_strobe           (o_strobe),
        .o_normalized_value (o_normalized_value),
        .o_center_value     (o_center_value),
        .o_result_last      (o_result_last),
        .o_no_valid_samples (o_no_valid_samples),
        .o_overflow_dropped (o_overflow_dropped),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitors. Both sample at the rising edge, so they see the values that
    // were on the wires during the cycle that edge ends.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_request(i_sample_value, i_sample_valid, i_sequence_last);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result('{o_normalized_value, o_center_value, o_result_last,
                              o_no_valid_samples, o_overflow_dropped});
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Start is left
    // high on return, so back-to-back requests need no extra edge; start drops
    // only in an idle cycle before the next request and in drain().
    task automatic send_request(input logic [SAMPLE_W-1:0] value, input logic valid,
                                input logic last);
        while (gaps_on && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_sample_value  <= value;
        i_sample_valid  <= valid;
        i_sequence_last <= last;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait until every predicted result has been seen, then
    // give the block time to finish any tail work before it is touched again.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Two-phase register write. Only called while the block is idle.
    task automatic write_reg(input logic reg_index, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == REG_SCALE_DIVISOR)
            sb.set_divisor(data[DIVISOR_W-1:0]);
    endtask

    // Half extremes, zero and small values around zero, the rest fully random.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3, 4:    return SAMPLE_W'($urandom_range(0, 1 << 19)) - SAMPLE_W'(1 << 18);
            default: return $urandom();
        endcase
    endfunction

    // Short sequences dominate; some are long, a few fill or overrun the buffer.
    function automatic int pick_length(int seq_no);
        int roll;
        if (seq_no == 0) return DEPTH + 1 + $urandom_range(0, 4);
        if (seq_no == 1) return DEPTH;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 10);
        if (roll < 85) return $urandom_range(11, 40);
        if (roll < 95) return $urandom_range(DEPTH - 4, DEPTH);
        return $urandom_range(DEPTH + 1, DEPTH + 6);
    endfunction

    function automatic logic [PDATA_W-1:0] pick_divisor(int phase);
        case (phase % 6)
            0:       return $urandom_range(1, 256);
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000 | $urandom_range(1, 1 << 20);   // top bit ignored
            3:       return 32'd65536 + $urandom_range(0, 1024) - 512;
            4:       return $urandom_range(1, 32'h7FFF_FFFF);
            default: return 32'd1;
        endcase
    endfunction

    initial begin
        int seq_no;
        int sent;
        int len;
        bit all_masked;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset divisor of 1.0 first.
        // A single valid sample at the positive extreme is its own center.
        send_request(Q_MAX, 1'b1, 1'b1);
        // Both extremes: the center rounds down to -1 and the top end saturates.
        send_request(Q_MIN, 1'b1, 1'b0);
        send_request(Q_MAX, 1'b1, 1'b1);
        // No valid sample at all: the center is zero and the flag is set.
        send_request(32'h1234_5678, 1'b0, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0, 1'b1);
        // A masked extreme must not move the midrange; even negative sum.
        send_request(32'd5, 1'b1, 1'b0);
        send_request(Q_MIN, 1'b0, 1'b0);
        send_request(-32'sd7, 1'b1, 1'b1);

        // Smallest divisor: most results saturate in one direction or the other.
        drain();
        write_reg(REG_SCALE_DIVISOR, 32'd1);
        send_request(32'h0001_0000, 1'b1, 1'b0);
        send_request(32'hFFFF_0000, 1'b1, 1'b1);

        // Largest divisor, written with the unused top bit set as well.
        drain();
        write_reg(REG_SCALE_DIVISOR, 32'hFFFF_FFFF);
        send_request(Q_MAX, 1'b1, 1'b0);
        send_request(Q_MIN, 1'b1, 1'b1);

        // A zero divisor behaves as one.
        drain();
        write_reg(REG_SCALE_DIVISOR, 32'd0);
        send_request(32'd3, 1'b1, 1'b0);
        send_request(32'h4000_0000, 1'b0, 1'b1);

        // A write to the unmapped slot changes nothing.
        drain();
        write_reg(REG_UNMAPPED, 32'd5);
        send_request(32'h0000_8000, 1'b1, 1'b1);

        // Random part: a new divisor every few sequences, each written after
        // the block has gone quiet. A stretch in the middle runs with no gaps.
        seq_no = 0;
        sent   = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seq_no % 4 == 0) begin
                drain();
                write_reg(REG_SCALE_DIVISOR, pick_divisor(seq_no / 4));
            end
            len        = pick_length(seq_no);
            all_masked = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++) begin
                gaps_on = !(sent >= 150 && sent < 250);
                send_request(pick_sample(), all_masked ? 1'b0 : ($urandom_range(0, 4) != 0),
                             i == len - 1);
                sent++;
            end
            seq_no++;
        end

        drain();
        if (sb.failures() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
sv/mmcn_pkg.sv
sv/mmcn_store.sv
sv/mmcn_div.sv
sv/masked_midrange_center_normalize.sv
sim/tb.sv
